### design/lwfa_pkg.sv
// Package for the Lennard-Jones wall force accumulator.
// Shared widths, register indexes, a handshake struct and saturating helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lwfa_pkg;

  localparam int unsigned CoordW    = 32;
  localparam int unsigned CutoffW   = 31;
  localparam int unsigned CoeffW    = 48;
  localparam int unsigned ResW      = 64;
  localparam int unsigned CfgDataW  = 48;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned QuotW     = 49;
  localparam int unsigned DivCntW   = 6;

  localparam logic [CfgIdxW-1:0] RegWallPos  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCutoff   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSide     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegFrc      = 3'd3;
  localparam logic [CfgIdxW-1:0] RegFac      = 3'd4;
  localparam logic [CfgIdxW-1:0] RegErc      = 3'd5;
  localparam logic [CfgIdxW-1:0] RegEac      = 3'd6;
  localparam logic [CfgIdxW-1:0] RegEshift   = 3'd7;

  localparam logic [CutoffW-1:0] CutoffReset = 31'd65536;

  // Request to the shared multiplier.
  typedef struct packed {
    logic start;
    logic signed_mode;
    logic neg;
    logic shift24;
  } mul_req_t;

  function automatic logic [ResW-1:0] sat_add(input logic [ResW-1:0] a,
                                              input logic [ResW-1:0] b);
    logic [ResW:0] s;
    s = {a[ResW-1], a} + {b[ResW-1], b};
    if (s[ResW] != s[ResW-1]) begin
      return s[ResW] ? {1'b1, {(ResW-1){1'b0}}} : {1'b0, {(ResW-1){1'b1}}};
    end
    return s[ResW-1:0];
  endfunction

  function automatic logic [ResW-1:0] sat_sub(input logic [ResW-1:0] a,
                                              input logic [ResW-1:0] b);
    logic [ResW:0] s;
    s = {a[ResW-1], a} - {b[ResW-1], b};
    if (s[ResW] != s[ResW-1]) begin
      return s[ResW] ? {1'b1, {(ResW-1){1'b0}}} : {1'b0, {(ResW-1){1'b1}}};
    end
    return s[ResW-1:0];
  endfunction

endpackage
`default_nettype wire

### design/lwfa_div.sv
// Restoring divider producing floor(2^48 / divisor), one quotient bit per cycle.
// Depends on lwfa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lwfa_div
  import lwfa_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [CutoffW-1:0] divisor_i,
  output logic                    done_o,
  output logic [QuotW-1:0]        quot_o
);

  logic               busy_q;
  logic [DivCntW-1:0] cnt_q;
  logic [CutoffW-1:0] rem_q;
  logic [CutoffW-1:0] div_q;
  logic [CutoffW:0]   rem_sh;
  logic               ge;

  // The dividend is a single one at the top bit.
  assign rem_sh = {rem_q, (cnt_q == DivCntW'(QuotW - 1))};
  assign ge     = rem_sh >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= !start_i && busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DivCntW'(QuotW - 1);
        rem_q  <= '0;
        div_q  <= divisor_i;
      end else if (busy_q) begin
        rem_q  <= ge ? CutoffW'(rem_sh - {1'b0, div_q}) : rem_sh[CutoffW-1:0];
        quot_o <= {quot_o[QuotW-2:0], ge};
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

### design/lwfa_mul.sv
// Shared 64x64 multiplier built from four registered 32x32 partial products,
// followed by a shift, saturation and optional sign restore. Depends on lwfa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lwfa_mul
  import lwfa_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire mul_req_t        req_i,
  input  wire logic [ResW-1:0] a_i,
  input  wire logic [ResW-1:0] b_i,
  output logic                 done_o,
  output logic [ResW-1:0]      res_o
);

  logic [ResW-1:0]   a_q, b_q, pp_q;
  logic              sgn_q, neg_q, sh24_q, busy_q;
  logic [2:0]        ph_q;
  logic [1:0]        pidx_q;
  logic [2*ResW-1:0] acc_q, acc_add;
  logic [31:0]       ah, bh;
  logic [ResW-1:0]   p, fin;
  logic              ovf;

  assign ah = ph_q[1] ? a_q[63:32] : a_q[31:0];
  assign bh = ph_q[0] ? b_q[63:32] : b_q[31:0];

  always_comb begin
    case (pidx_q)
      2'd0:    acc_add = acc_q + {64'd0, pp_q};
      2'd3:    acc_add = acc_q + {pp_q, 64'd0};
      default: acc_add = acc_q + {32'd0, pp_q, 32'd0};
    endcase
  end

  always_comb begin
    if (sh24_q) begin
      ovf = |acc_q[127:88];
      p   = acc_q[87:24];
    end else begin
      ovf = |acc_q[127:96];
      p   = acc_q[95:32];
    end
    if (ovf) p = '1;
    if (!sgn_q) begin
      fin = p;
    end else if (neg_q) begin
      fin = p[63] ? {1'b1, 63'd0} : 64'(0 - p);
    end else begin
      fin = p[63] ? {1'b0, {63{1'b1}}} : p;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      ph_q   <= '0;
    end else begin
      done_o <= !req_i.start && busy_q && (ph_q == 3'd5);
      if (req_i.start) begin
        busy_q <= 1'b1;
        ph_q   <= '0;
        acc_q  <= '0;
        a_q    <= a_i;
        b_q    <= b_i;
        sgn_q  <= req_i.signed_mode;
        neg_q  <= req_i.neg;
        sh24_q <= req_i.shift24;
      end else if (busy_q) begin
        if (ph_q < 3'd4) begin
          pp_q   <= {32'd0, ah} * {32'd0, bh};
          pidx_q <= ph_q[1:0];
        end
        if (ph_q != 3'd0 && ph_q < 3'd5) acc_q <= acc_add;
        if (ph_q == 3'd5) begin
          res_o  <= fin;
          busy_q <= 1'b0;
        end else begin
          ph_q <= ph_q + 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

### design/lj_wall_force_accumulator.sv
// Top level of the Lennard-Jones 12-6 wall force accumulator.
// Depends on lwfa_pkg, lwfa_div and lwfa_mul.
//
//  Channel   Direction  Contents
//  s_axis    in         tdata: particle_coord; tuser: in_group; tlast: last_particle
//  m_axis    out        tdata: wall_force, energy_term, force_total, energy_total;
//                       tuser: on_wall, any_on_wall; tlast: pass_done
//  cfg       in         write enable, register index, write data (no read-back)
//
// A particle that is skipped, out of group or on the wall goes from StClass to StOut.
// A particle inside the cutoff runs the bit-serial divider for the reciprocal,
// then eight products on the shared multiplier, all sequenced one after another.
// Reset clears the sums, the contact flag and the registers to their defaults.
// The next particle is taken while a finished result still waits on m_axis;
// the block stalls only when a new result is ready and the last one is untaken.
`timescale 1ns / 1ps
`default_nettype none
module lj_wall_force_accumulator
  import lwfa_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [CoordW-1:0]   s_axis_tdata,   // [31:0] particle_coord
  input  wire logic                s_axis_tuser,   // [0] in_group
  input  wire logic                s_axis_tlast,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [4*ResW-1:0]        m_axis_tdata,   // wall_force, energy_term,
                                                   // force_total, energy_total
  output logic [1:0]               m_axis_tuser,   // [0] on_wall, [1] any_on_wall
  output logic                     m_axis_tlast
);

  typedef enum logic [2:0] {
    StIdle, StClass, StDiv, StMulGo, StMulWait, StOut
  } state_e;

  typedef enum logic [2:0] {
    OpR2, OpR4, OpR6, OpFt, OpF2, OpF3, OpEt, OpE2
  } op_e;

  // Configuration registers.
  logic [CoordW-1:0]  wall_q;
  logic [CutoffW-1:0] cut_q;
  logic               side_q;
  logic [CoeffW-1:0]  frc_q, fac_q, erc_q, eac_q, esh_q;

  state_e            state_q;
  op_e               op_q;
  logic [CoordW-1:0] x_q;
  logic              grp_q, last_q, onw_q;
  logic [ResW-1:0]   rinv_q, r2_q, r4_q, r6_q, fi_q, t2_q, f_q, ei_q;
  logic [ResW-1:0]   fw_q, et_q, fsum_q, esum_q;
  logic              seen_q;

  // Distance to the wall, sign-extended by one bit so that it cannot wrap.
  logic signed [CoordW:0] wall_dist;
  logic                   beyond, behind;

  assign wall_dist = side_q ? ($signed({wall_q[CoordW-1], wall_q}) -
                               $signed({x_q[CoordW-1], x_q}))
                            : ($signed({x_q[CoordW-1], x_q}) -
                               $signed({wall_q[CoordW-1], wall_q}));
  assign beyond = wall_dist >= $signed({2'b00, cut_q});
  assign behind = wall_dist[CoordW] || (wall_dist == '0);

  logic              div_start, div_done;
  logic [QuotW-1:0]  quot;

  lwfa_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (wall_dist[CutoffW-1:0]),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  assign div_start = (state_q == StClass) && grp_q && !beyond && !behind;

  // Operand selection for the shared multiplier.
  mul_req_t        mreq;
  logic [ResW-1:0] ma, mb, sa;
  logic            mul_done;
  logic [ResW-1:0] mres;

  always_comb begin
    sa            = '0;
    mb            = r6_q;
    mreq.start    = (state_q == StMulGo);
    mreq.signed_mode = 1'b1;
    mreq.shift24  = 1'b0;
    case (op_q)
      OpR2: begin sa = rinv_q; mb = rinv_q; mreq.signed_mode = 1'b0; end
      OpR4: begin sa = r2_q;   mb = r2_q;   mreq.signed_mode = 1'b0; end
      OpR6: begin sa = r4_q;   mb = r2_q;   mreq.signed_mode = 1'b0; end
      OpFt: sa = {{(ResW-CoeffW){frc_q[CoeffW-1]}}, frc_q};
      OpF2: sa = fi_q;
      OpF3: begin sa = t2_q; mb = rinv_q; mreq.shift24 = 1'b1; end
      OpEt: sa = {{(ResW-CoeffW){erc_q[CoeffW-1]}}, erc_q};
      OpE2: begin sa = ei_q; mreq.shift24 = 1'b1; end
      default: sa = '0;
    endcase
    mreq.neg = mreq.signed_mode && sa[ResW-1];
    ma       = mreq.neg ? ResW'(0 - sa) : sa;
  end

  lwfa_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .a_i    (ma),
    .b_i    (mb),
    .done_o (mul_done),
    .res_o  (mres)
  );

  logic [ResW-1:0] fac_x, eac_x, esh_x, f_neg, e_term;
  logic [ResW-1:0] fsum_d, esum_d;
  logic            seen_d;

  assign fac_x  = {{(ResW-CoeffW){fac_q[CoeffW-1]}}, fac_q};
  assign eac_x  = {{(ResW-CoeffW){eac_q[CoeffW-1]}}, eac_q};
  // The energy shift is Q24.24; scale it to Q32.32.
  assign esh_x  = {{(ResW-CoeffW-8){esh_q[CoeffW-1]}}, esh_q, 8'd0};
  assign f_neg  = (f_q == {1'b1, 63'd0}) ? {1'b0, {63{1'b1}}} : ResW'(0 - f_q);
  assign e_term = sat_sub(mres, esh_x);

  assign fsum_d = sat_add(fsum_q, fw_q);
  assign esum_d = sat_add(esum_q, et_q);
  assign seen_d = seen_q | onw_q;

  assign s_axis_tready = (state_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      op_q          <= OpR2;
      m_axis_tvalid <= 1'b0;
      fsum_q        <= '0;
      esum_q        <= '0;
      seen_q        <= 1'b0;
      wall_q        <= '0;
      cut_q         <= CutoffReset;
      side_q        <= 1'b0;
      frc_q         <= '0;
      fac_q         <= '0;
      erc_q         <= '0;
      eac_q         <= '0;
      esh_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegWallPos: wall_q <= cfg_data_i[CoordW-1:0];
          RegCutoff:  cut_q  <= cfg_data_i[CutoffW-1:0];
          RegSide:    side_q <= cfg_data_i[0];
          RegFrc:     frc_q  <= cfg_data_i[CoeffW-1:0];
          RegFac:     fac_q  <= cfg_data_i[CoeffW-1:0];
          RegErc:     erc_q  <= cfg_data_i[CoeffW-1:0];
          RegEac:     eac_q  <= cfg_data_i[CoeffW-1:0];
          RegEshift:  esh_q  <= cfg_data_i[CoeffW-1:0];
          default:    ;
        endcase
      end

      // In StOut the transfer of a waiting result is handled below.
      if (m_axis_tvalid && m_axis_tready && (state_q != StOut)) m_axis_tvalid <= 1'b0;

      unique case (state_q)
        StIdle: begin
          if (s_axis_tvalid) begin
            x_q     <= s_axis_tdata;
            grp_q   <= s_axis_tuser;
            last_q  <= s_axis_tlast;
            state_q <= StClass;
          end
        end
        StClass: begin
          // Skipped, out of group or in contact: the result is ready at once.
          fw_q  <= '0;
          et_q  <= '0;
          onw_q <= grp_q && !beyond && behind;
          if (div_start) begin
            state_q <= StDiv;
          end else begin
            state_q <= StOut;
          end
        end
        StDiv: begin
          if (div_done) begin
            rinv_q  <= ResW'(quot);
            op_q    <= OpR2;
            state_q <= StMulGo;
          end
        end
        StMulGo: state_q <= StMulWait;
        StMulWait: begin
          if (mul_done) begin
            op_q <= op_e'(op_q + 1'b1);
            if (op_q == OpE2) begin
              state_q <= StOut;
            end else begin
              state_q <= StMulGo;
            end
            unique case (op_q)
              OpR2: r2_q <= mres;
              OpR4: r4_q <= mres;
              OpR6: r6_q <= mres;
              OpFt: fi_q <= sat_sub(mres, fac_x);
              OpF2: t2_q <= mres;
              OpF3: f_q  <= mres;
              OpEt: ei_q <= sat_sub(mres, eac_x);
              OpE2: begin
                fw_q <= side_q ? f_q : f_neg;
                et_q <= e_term;
              end
              default: ;
            endcase
          end
        end
        StOut: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {esum_d, fsum_d, et_q, fw_q};
            m_axis_tuser  <= {seen_d, onw_q};
            m_axis_tlast  <= last_q;
            // The totals reported include this particle; the last one clears them.
            fsum_q        <= last_q ? '0 : fsum_d;
            esum_q        <= last_q ? '0 : esum_d;
            seen_q        <= last_q ? 1'b0 : seen_d;
            state_q       <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule
`default_nettype wire
